// ===== rtl/h264_pps_header_parser_top_assert.svh =====
// Assertion macros shared by the parameter set parser modules.
// Depends on nothing; included inside module bodies.
`ifndef H264_PPS_HEADER_PARSER_TOP_ASSERT_SVH
`define H264_PPS_HEADER_PARSER_TOP_ASSERT_SVH
// Checks that a condition implies a consequence in the same cycle.
`define PPS_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define PPS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`endif

// ===== rtl/hpps_pkg.sv =====
// Package for the parameter set parser: syntax steps, status codes and limits.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hpps_pkg;
   localparam int unsigned MaxSliceGroups = 8;
   localparam int unsigned MaxMapUnits    = 4194304;
   localparam int unsigned QueueDepth     = 2;

   typedef enum logic [4:0] {
      ST_PPS_ID, ST_SPS_ID, ST_ENTROPY, ST_BOTTOM, ST_NUM_GROUPS, ST_MAP_TYPE,
      ST_MAP_UE, ST_MAP_DIR, ST_MAP_RATE, ST_MAP_SIZE, ST_MAP_IDS, ST_REF0,
      ST_REF1, ST_WP, ST_BIPRED, ST_QP, ST_QS, ST_CQP, ST_DEBLOCK, ST_CIP,
      ST_RED, ST_EXT_CHECK, ST_T8, ST_SMP, ST_LIST_FLAG, ST_LIST_DELTA,
      ST_CQP2, ST_DONE, ST_ERR, ST_MAP_SIZE_MUL
   } step_type;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_MALFORMED = 3'd1;
   localparam logic [2:0] STATUS_GROUPS    = 3'd2;
   localparam logic [2:0] STATUS_MAP_TYPE  = 3'd3;
   localparam logic [2:0] STATUS_MAP_SIZE  = 3'd4;

   // One queued request between the front and the back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   // One result.
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] param_set_id;
      logic [31:0] seq_set_id;
      logic        entropy_mode;
      logic [31:0] ref_count_l0_minus1;
      logic [31:0] ref_count_l1_minus1;
      logic [31:0] init_qp_minus26;
      logic        deblock_control_present;
      logic        xform8_flag;
   } rsp_type;

   // Bits needed to code a group id for a group count minus one.
   function automatic logic [1:0] id_bits(input logic [2:0] g);
      logic [1:0] r;
      begin
         if (g == 3'd0)      r = 2'd0;
         else if (g == 3'd1) r = 2'd1;
         else if (g <= 3'd3) r = 2'd2;
         else                r = 2'd3;
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/h264_pps_header_parser_top.sv =====
// Top level of the picture parameter set parser.
// Depends on hpps_pkg, hpps_front and hpps_back.
`timescale 1ns / 1ps
`default_nettype none
// Takes one RBSP byte per request and decodes it one bit per clock, except
// where the engine loads a byte from the two-entry input queue or takes a
// step that reads no bit: the extension check and the step after the map size
// code. Each byte is loaded and then walked through its eight bits. A byte in
// which parsing completes or fails stops at that bit, and a byte that arrives
// after completion or an error is loaded and dropped. The final byte also posts
// the result, and waits while the previous result has not been popped. Requests
// queue while the bit engine works, and the single result register holds a
// status and the kept fields until it is popped.
module h264_pps_header_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_final_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_param_set_id,
   output logic [31:0]      rsp_seq_set_id,
   output logic             rsp_entropy_mode,
   output logic [31:0]      rsp_ref_count_l0_minus1,
   output logic [31:0]      rsp_ref_count_l1_minus1,
   output logic signed [31:0] rsp_init_qp_minus26,
   output logic             rsp_deblock_control_present,
   output logic             rsp_xform8_flag
);
   import hpps_pkg::*;

   logic    q_valid, q_take, rsp_valid;
   req_type q_data;
   rsp_type rsp_data;

   hpps_front u_front (
      .clock, .reset, .push, .full, .req_data_byte, .req_final_byte,
      .q_valid, .q_data, .q_take
   );

   hpps_back u_back (
      .clock, .reset, .q_valid, .q_data, .q_take,
      .rsp_valid, .rsp_data, .rsp_take(pop)
   );

   // Result ports.
   assign empty                       = !rsp_valid;
   assign rsp_status                  = rsp_data.status;
   assign rsp_param_set_id            = rsp_data.param_set_id;
   assign rsp_seq_set_id              = rsp_data.seq_set_id;
   assign rsp_entropy_mode            = rsp_data.entropy_mode;
   assign rsp_ref_count_l0_minus1     = rsp_data.ref_count_l0_minus1;
   assign rsp_ref_count_l1_minus1     = rsp_data.ref_count_l1_minus1;
   assign rsp_init_qp_minus26         = rsp_data.init_qp_minus26;
   assign rsp_deblock_control_present = rsp_data.deblock_control_present;
   assign rsp_xform8_flag             = rsp_data.xform8_flag;
endmodule
`default_nettype wire

// ===== rtl/hpps_front.sv =====
// Front end: accepts request bytes into a short queue for the bit engine.
// Depends on hpps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpps_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_final_byte,
   output logic                  q_valid,
   output hpps_pkg::req_type     q_data,
   input  wire logic             q_take
);
   import hpps_pkg::*;
   `include "h264_pps_header_parser_top_assert.svh"

   req_type    mem_ff [QueueDepth];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'(QueueDepth));
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data  = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   // Pointer and count update.
   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   // Queue storage and control.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= '{data_byte: req_data_byte, final_byte: req_final_byte};
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `PPS_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 2'(QueueDepth), "queue overflow")
   `PPS_ASSERT_NEXT(a_push_count, clock, reset, do_push && !do_pop, cnt_ff == $past(cnt_ff) + 2'd1, "push lost")
   `PPS_ASSERT_IMPL(a_ptr_agree, clock, reset, cnt_ff == 2'd1, wr_ff != rd_ff, "pointers disagree")
endmodule
`default_nettype wire

// ===== rtl/hpps_back.sv =====
// Back end: walks the bits of each byte through the parameter set syntax.
// Depends on hpps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpps_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire hpps_pkg::req_type q_data,
   output logic               q_take,
   output logic               rsp_valid,
   output hpps_pkg::rsp_type  rsp_data,
   input  wire logic          rsp_take
);
   import hpps_pkg::*;
   `include "h264_pps_header_parser_top_assert.svh"

   typedef enum logic [1:0] {S_LOAD, S_BITS, S_EMIT} phase_type;

   phase_type   phase_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [2:0]  pos_ff;
   step_type    step_ff;
   logic [5:0]  lz_ff;
   logic [32:0] acc_ff;
   logic        suf_ff;
   logic [2:0]  grp_ff;
   logic [23:0] loop_ff;
   logic [2:0]  li_ff;
   logic [7:0]  ls_ff;
   logic [2:0]  err_ff;
   logic [31:0] pps_ff, sps_ff, r0_ff, r1_ff, qp_ff;
   logic        ent_ff, dbk_ff, t8_ff;
   logic [21:0] mul_v_ff;
   logic        out_full_ff;
   rsp_type     out_ff;

   logic        bit_v, ex_more, ue_done, ue_err;
   logic [31:0] code_v, se_v;
   logic        ue_step, end_byte;
   logic [7:0]  scale_sum;
   logic [7:0]  low_mask;
   logic        emit_go;

   assign bit_v    = byte_ff[3'd7 - pos_ff];
   assign low_mask = (8'd1 << (3'd7 - pos_ff)) - 8'd1;
   assign ex_more  = !last_ff || ((byte_ff & low_mask) != 8'd0);
   assign q_take   = (phase_ff == S_LOAD) && q_valid;
   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;
   assign emit_go   = (phase_ff == S_EMIT) && (!out_full_ff || rsp_take);

   // Steps that read an Exp-Golomb code.
   always_comb begin
      case (step_ff)
         ST_PPS_ID, ST_SPS_ID, ST_NUM_GROUPS, ST_MAP_TYPE, ST_MAP_UE, ST_MAP_RATE,
         ST_MAP_SIZE, ST_REF0, ST_REF1, ST_QP, ST_QS, ST_CQP, ST_LIST_DELTA,
         ST_CQP2: ue_step = 1'b1;
         default: ue_step = 1'b0;
      endcase
   end

   // One Exp-Golomb bit.
   always_comb begin
      ue_done = 1'b0;
      ue_err  = 1'b0;
      code_v  = 32'd0;
      if (!suf_ff) begin
         if (!bit_v) ue_err = (lz_ff >= 6'd31);
         else if (lz_ff == 6'd0) ue_done = 1'b1;
      end else if (lz_ff == 6'd1) begin
         ue_done = 1'b1;
         code_v  = 32'({acc_ff[31:0], bit_v} - 33'd1);
      end
   end

   assign se_v      = code_v[0] ? ({1'b0, code_v[31:1]} + 32'd1)
                                : (32'd0 - {1'b0, code_v[31:1]});
   assign scale_sum = ls_ff + se_v[7:0];
   assign end_byte  = (pos_ff == 3'd7);

   // Bit engine sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= S_LOAD;
         pos_ff <= 3'd0; step_ff <= ST_PPS_ID; lz_ff <= 6'd0; acc_ff <= 33'd0;
         suf_ff <= 1'b0; grp_ff <= 3'd0; loop_ff <= 24'd0; li_ff <= 3'd0;
         ls_ff <= 8'd8; err_ff <= STATUS_OK;
         pps_ff <= '0; sps_ff <= '0; r0_ff <= '0; r1_ff <= '0; qp_ff <= '0;
         ent_ff <= 1'b0; dbk_ff <= 1'b0; t8_ff <= 1'b0; out_full_ff <= 1'b0;
         byte_ff <= 8'd0; last_ff <= 1'b0; mul_v_ff <= 22'd0;
      end else begin
         out_full_ff <= emit_go || (out_full_ff && !rsp_take);
         case (phase_ff)
            S_LOAD: begin
               if (q_valid) begin
                  byte_ff  <= q_data.data_byte;
                  last_ff  <= q_data.final_byte;
                  pos_ff   <= 3'd0;
                  phase_ff <= S_BITS;
               end
            end
            S_BITS: begin
               if (step_ff == ST_DONE || step_ff == ST_ERR) begin
                  phase_ff <= last_ff ? S_EMIT : S_LOAD;
               end else if (step_ff == ST_EXT_CHECK) begin
                  step_ff <= ex_more ? ST_T8 : ST_DONE;
               end else if (step_ff == ST_MAP_SIZE_MUL) begin
                  loop_ff <= 24'(({2'b0, mul_v_ff} + 24'd1) * id_bits(grp_ff));
                  step_ff <= (id_bits(grp_ff) != 2'd0) ? ST_MAP_IDS : ST_REF0;
               end else begin
                  if (end_byte) phase_ff <= last_ff ? S_EMIT : S_LOAD;
                  pos_ff <= pos_ff + 3'd1;
                  if (ue_step) begin
                     if (ue_err) begin
                        err_ff <= STATUS_MALFORMED; step_ff <= ST_ERR;
                     end else if (!suf_ff) begin
                        if (!bit_v) lz_ff <= lz_ff + 6'd1;
                        else if (lz_ff != 6'd0) begin acc_ff <= 33'd1; suf_ff <= 1'b1; end
                     end else begin
                        acc_ff <= ue_done ? 33'd0 : {acc_ff[31:0], bit_v};
                        lz_ff  <= lz_ff - 6'd1;
                        if (ue_done) suf_ff <= 1'b0;
                     end
                     if (ue_done) begin
                        case (step_ff)
                           ST_PPS_ID: begin pps_ff <= code_v; step_ff <= ST_SPS_ID; end
                           ST_SPS_ID: begin sps_ff <= code_v; step_ff <= ST_ENTROPY; end
                           ST_NUM_GROUPS: begin
                              if (code_v > 32'(MaxSliceGroups - 1)) begin
                                 err_ff <= STATUS_GROUPS; step_ff <= ST_ERR;
                              end else begin
                                 grp_ff  <= code_v[2:0];
                                 step_ff <= (code_v != 32'd0) ? ST_MAP_TYPE : ST_REF0;
                              end
                           end
                           ST_MAP_TYPE: begin
                              if (code_v == 32'd0) begin
                                 loop_ff <= 24'(grp_ff) + 24'd1; step_ff <= ST_MAP_UE;
                              end else if (code_v == 32'd1) step_ff <= ST_REF0;
                              else if (code_v == 32'd2) begin
                                 loop_ff <= {20'd0, grp_ff, 1'b0}; step_ff <= ST_MAP_UE;
                              end else if (code_v <= 32'd5) step_ff <= ST_MAP_DIR;
                              else if (code_v == 32'd6) step_ff <= ST_MAP_SIZE;
                              else begin err_ff <= STATUS_MAP_TYPE; step_ff <= ST_ERR; end
                           end
                           ST_MAP_UE: begin
                              loop_ff <= loop_ff - 24'd1;
                              if (loop_ff == 24'd1) step_ff <= ST_REF0;
                           end
                           ST_MAP_RATE: step_ff <= ST_REF0;
                           ST_MAP_SIZE: begin
                              if (code_v >= 32'(MaxMapUnits)) begin
                                 err_ff <= STATUS_MAP_SIZE; step_ff <= ST_ERR;
                              end else begin
                                 mul_v_ff <= code_v[21:0]; step_ff <= ST_MAP_SIZE_MUL;
                              end
                           end
                           ST_REF0: begin r0_ff <= code_v; step_ff <= ST_REF1; end
                           ST_REF1: begin r1_ff <= code_v; step_ff <= ST_WP; end
                           ST_QP:   begin qp_ff <= se_v; step_ff <= ST_QS; end
                           ST_QS:   step_ff <= ST_CQP;
                           ST_CQP:  step_ff <= ST_DEBLOCK;
                           ST_LIST_DELTA: begin
                              if (scale_sum != 8'd0) ls_ff <= scale_sum;
                              if (scale_sum == 8'd0 || loop_ff == 24'd1) begin
                                 loop_ff <= 24'd0;
                                 li_ff <= li_ff + 3'd1;
                                 if ({1'b0, li_ff} + 4'd1 >= (t8_ff ? 4'd8 : 4'd6))
                                    step_ff <= ST_CQP2;
                                 else step_ff <= ST_LIST_FLAG;
                              end else loop_ff <= loop_ff - 24'd1;
                           end
                           ST_CQP2: step_ff <= ST_DONE;
                           default: ;
                        endcase
                     end
                  end else begin
                     case (step_ff)
                        ST_ENTROPY: begin ent_ff <= bit_v; step_ff <= ST_BOTTOM; end
                        ST_BOTTOM:  step_ff <= ST_NUM_GROUPS;
                        ST_MAP_DIR: step_ff <= ST_MAP_RATE;
                        ST_MAP_IDS: begin
                           loop_ff <= loop_ff - 24'd1;
                           if (loop_ff == 24'd1) step_ff <= ST_REF0;
                        end
                        ST_WP: begin loop_ff <= 24'd2; step_ff <= ST_BIPRED; end
                        ST_BIPRED: begin
                           loop_ff <= loop_ff - 24'd1;
                           if (loop_ff == 24'd1) step_ff <= ST_QP;
                        end
                        ST_DEBLOCK: begin dbk_ff <= bit_v; step_ff <= ST_CIP; end
                        ST_CIP: step_ff <= ST_RED;
                        ST_RED: step_ff <= ST_EXT_CHECK;
                        ST_T8:  begin t8_ff <= bit_v; step_ff <= ST_SMP; end
                        ST_SMP: begin
                           if (bit_v) begin li_ff <= 3'd0; step_ff <= ST_LIST_FLAG; end
                           else step_ff <= ST_CQP2;
                        end
                        ST_LIST_FLAG: begin
                           if (bit_v) begin
                              loop_ff <= (li_ff < 3'd6) ? 24'd16 : 24'd64;
                              ls_ff <= 8'd8; step_ff <= ST_LIST_DELTA;
                           end else begin
                              li_ff <= li_ff + 3'd1;
                              if ({1'b0, li_ff} + 4'd1 >= (t8_ff ? 4'd8 : 4'd6))
                                 step_ff <= ST_CQP2;
                              else step_ff <= ST_LIST_FLAG;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  if (step_ff == ST_DONE || step_ff == ST_EXT_CHECK) begin
                     out_ff <= '{status: STATUS_OK, param_set_id: pps_ff, seq_set_id: sps_ff,
                                 entropy_mode: ent_ff, ref_count_l0_minus1: r0_ff,
                                 ref_count_l1_minus1: r1_ff, init_qp_minus26: qp_ff,
                                 deblock_control_present: dbk_ff, xform8_flag: t8_ff};
                  end else begin
                     out_ff <= '{status: (step_ff == ST_ERR) ? err_ff : STATUS_MALFORMED,
                                 default: '0};
                  end
                  phase_ff <= S_LOAD;
                  step_ff <= ST_PPS_ID; lz_ff <= 6'd0; acc_ff <= 33'd0; suf_ff <= 1'b0;
                  grp_ff <= 3'd0; loop_ff <= 24'd0; li_ff <= 3'd0;
                  ls_ff <= 8'd8; err_ff <= STATUS_OK; pps_ff <= '0; sps_ff <= '0;
                  r0_ff <= '0; r1_ff <= '0; qp_ff <= '0; ent_ff <= 1'b0;
                  dbk_ff <= 1'b0; t8_ff <= 1'b0;
               end
            end
            default: phase_ff <= S_LOAD;
         endcase
      end
   end

   `PPS_ASSERT_IMPL(a_take_load, clock, reset, q_take, phase_ff == S_LOAD, "byte taken mid-parse")
   `PPS_ASSERT_IMPL(a_err_code, clock, reset, step_ff == ST_ERR, err_ff != STATUS_OK, "error without code")
   `PPS_ASSERT_NEXT(a_emit, clock, reset, phase_ff == S_EMIT && !out_full_ff, out_full_ff, "result lost")
endmodule
`default_nettype wire

// ===== dv/h264_pps_header_parser_top_tb.sv =====
// Testbench for the picture parameter set parser: drives RBSP bytes, predicts each result.
// Depends on hpps_pkg and h264_pps_header_parser_top.
`timescale 1ns / 1ps
`default_nettype none

// Predicts parser results and checks the responses against them in order.
class pps_scoreboard;
   // Parser state, mirroring the syntax walk.
   hpps_pkg::step_type step;
   int unsigned zeros;
   bit [63:0] acc;
   bit in_suffix;
   bit [2:0] groups_m1;
   bit [31:0] counter;
   bit [3:0] list_idx;
   bit [7:0] next_sc, last_sc;
   bit [2:0] err;
   hpps_pkg::rsp_type fields;
   hpps_pkg::rsp_type pending[$];
   int errors;
   int results_seen;
   int status_hits[5];

   function new();
      errors = 0;
      results_seen = 0;
      restart();
   endfunction

   function void restart();
      step = hpps_pkg::ST_PPS_ID;
      zeros = 0;
      acc = 0;
      in_suffix = 0;
      groups_m1 = 0;
      counter = 0;
      list_idx = 0;
      next_sc = 8;
      last_sc = 8;
      err = hpps_pkg::STATUS_OK;
      fields = '0;
   endfunction

   function void fail_with(bit [2:0] code);
      err = code;
      step = hpps_pkg::ST_ERR;
   endfunction

   function bit [31:0] signed_of(bit [31:0] k);
      if (k[0]) return (k >> 1) + 1;
      return 32'd0 - (k >> 1);
   endfunction

   function void next_list();
      list_idx++;
      if (list_idx >= (fields.xform8_flag ? 8 : 6)) step = hpps_pkg::ST_CQP2;
      else step = hpps_pkg::ST_LIST_FLAG;
   endfunction

   // Acts on one fully decoded Exp-Golomb value.
   function void take_code(bit [31:0] v);
      int unsigned nbits;
      case (step)
         hpps_pkg::ST_PPS_ID: begin
            fields.param_set_id = v; step = hpps_pkg::ST_SPS_ID;
         end
         hpps_pkg::ST_SPS_ID: begin
            fields.seq_set_id = v; step = hpps_pkg::ST_ENTROPY;
         end
         hpps_pkg::ST_NUM_GROUPS: begin
            if (v > hpps_pkg::MaxSliceGroups - 1) fail_with(hpps_pkg::STATUS_GROUPS);
            else begin
               groups_m1 = v[2:0];
               step = (v > 0) ? hpps_pkg::ST_MAP_TYPE : hpps_pkg::ST_REF0;
            end
         end
         hpps_pkg::ST_MAP_TYPE: begin
            if (v == 0) begin
               counter = groups_m1 + 1; step = hpps_pkg::ST_MAP_UE;
            end else if (v == 1) step = hpps_pkg::ST_REF0;
            else if (v == 2) begin
               counter = 2 * groups_m1; step = hpps_pkg::ST_MAP_UE;
            end else if (v <= 5) step = hpps_pkg::ST_MAP_DIR;
            else if (v == 6) step = hpps_pkg::ST_MAP_SIZE;
            else fail_with(hpps_pkg::STATUS_MAP_TYPE);
         end
         hpps_pkg::ST_MAP_UE: begin
            counter--;
            if (counter == 0) step = hpps_pkg::ST_REF0;
         end
         hpps_pkg::ST_MAP_RATE: step = hpps_pkg::ST_REF0;
         hpps_pkg::ST_MAP_SIZE: begin
            if (v >= hpps_pkg::MaxMapUnits) fail_with(hpps_pkg::STATUS_MAP_SIZE);
            else begin
               nbits = 0;
               while ((1 << nbits) < groups_m1 + 1) nbits++;
               counter = (v + 1) * nbits;
               step = (counter > 0) ? hpps_pkg::ST_MAP_IDS : hpps_pkg::ST_REF0;
            end
         end
         hpps_pkg::ST_REF0: begin
            fields.ref_count_l0_minus1 = v; step = hpps_pkg::ST_REF1;
         end
         hpps_pkg::ST_REF1: begin
            fields.ref_count_l1_minus1 = v; step = hpps_pkg::ST_WP;
         end
         hpps_pkg::ST_QP: begin
            fields.init_qp_minus26 = signed_of(v); step = hpps_pkg::ST_QS;
         end
         hpps_pkg::ST_QS: step = hpps_pkg::ST_CQP;
         hpps_pkg::ST_CQP: step = hpps_pkg::ST_DEBLOCK;
         hpps_pkg::ST_LIST_DELTA: begin
            next_sc = last_sc + signed_of(v);
            if (next_sc != 0) last_sc = next_sc;
            counter--;
            if (next_sc == 0) counter = 0;
            if (counter == 0) next_list();
            else step = hpps_pkg::ST_LIST_DELTA;
         end
         hpps_pkg::ST_CQP2: step = hpps_pkg::ST_DONE;
         default: ;
      endcase
   endfunction

   // Consumes one bit in syntax order.
   function void take_bit(bit b);
      case (step)
         hpps_pkg::ST_ENTROPY: begin
            fields.entropy_mode = b; step = hpps_pkg::ST_BOTTOM;
         end
         hpps_pkg::ST_BOTTOM: step = hpps_pkg::ST_NUM_GROUPS;
         hpps_pkg::ST_MAP_DIR: step = hpps_pkg::ST_MAP_RATE;
         hpps_pkg::ST_MAP_IDS: begin
            counter--;
            if (counter == 0) step = hpps_pkg::ST_REF0;
         end
         hpps_pkg::ST_WP: begin
            counter = 2; step = hpps_pkg::ST_BIPRED;
         end
         hpps_pkg::ST_BIPRED: begin
            counter--;
            if (counter == 0) step = hpps_pkg::ST_QP;
         end
         hpps_pkg::ST_DEBLOCK: begin
            fields.deblock_control_present = b; step = hpps_pkg::ST_CIP;
         end
         hpps_pkg::ST_CIP: step = hpps_pkg::ST_RED;
         hpps_pkg::ST_RED: step = hpps_pkg::ST_EXT_CHECK;
         hpps_pkg::ST_T8: begin
            fields.xform8_flag = b; step = hpps_pkg::ST_SMP;
         end
         hpps_pkg::ST_SMP: begin
            if (b) begin
               list_idx = 0; step = hpps_pkg::ST_LIST_FLAG;
            end else step = hpps_pkg::ST_CQP2;
         end
         hpps_pkg::ST_LIST_FLAG: begin
            if (b) begin
               counter = (list_idx < 6) ? 16 : 64;
               next_sc = 8;
               last_sc = 8;
               step = hpps_pkg::ST_LIST_DELTA;
            end else next_list();
         end
         hpps_pkg::ST_EXT_CHECK, hpps_pkg::ST_DONE, hpps_pkg::ST_ERR: ;
         default: begin
            // Exp-Golomb: count zeros, then read as many suffix bits.
            if (!in_suffix) begin
               if (!b) begin
                  if (zeros >= 31) fail_with(hpps_pkg::STATUS_MALFORMED);
                  else zeros++;
               end else if (zeros == 0) take_code(0);
               else begin
                  acc = 1; in_suffix = 1;
               end
            end else begin
               acc = (acc << 1) | b;
               zeros--;
               if (zeros == 0) begin
                  in_suffix = 0;
                  take_code(acc - 1);
                  acc = 0;
               end
            end
         end
      endcase
   endfunction

   // Notes an accepted request and queues a result on the final byte.
   function void note_request(bit [7:0] data, bit last);
      int unsigned p;
      bit [2:0] status;
      hpps_pkg::rsp_type r;
      p = 0;
      while (p < 8 && step != hpps_pkg::ST_DONE && step != hpps_pkg::ST_ERR) begin
         if (step == hpps_pkg::ST_EXT_CHECK) begin
            if (!last || ((data & ((1 << (7 - p)) - 1)) != 0)) step = hpps_pkg::ST_T8;
            else step = hpps_pkg::ST_DONE;
         end else begin
            take_bit(data[7 - p]);
            p++;
         end
      end
      if (!last) return;
      if (step == hpps_pkg::ST_ERR) status = err;
      else if (step == hpps_pkg::ST_DONE || step == hpps_pkg::ST_EXT_CHECK)
         status = hpps_pkg::STATUS_OK;
      else status = hpps_pkg::STATUS_MALFORMED;
      r = '0;
      if (status == hpps_pkg::STATUS_OK) r = fields;
      r.status = status;
      pending.push_back(r);
      restart();
   endfunction

   function void check_one(string name, bit [31:0] want, bit [31:0] got);
      if (want !== got) begin
         $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name, want, got);
         errors++;
      end
   endfunction

   // Checks one popped result against the oldest prediction.
   function void check_result(hpps_pkg::rsp_type got);
      hpps_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual status %0d",
                  $realtime, got.status);
         errors++;
         return;
      end
      want = pending.pop_front();
      results_seen++;
      if (want.status <= hpps_pkg::STATUS_MAP_SIZE) status_hits[want.status]++;
      check_one("status", want.status, got.status);
      check_one("param_set_id", want.param_set_id, got.param_set_id);
      check_one("seq_set_id", want.seq_set_id, got.seq_set_id);
      check_one("entropy_mode", want.entropy_mode, got.entropy_mode);
      check_one("ref_count_l0_minus1", want.ref_count_l0_minus1, got.ref_count_l0_minus1);
      check_one("ref_count_l1_minus1", want.ref_count_l1_minus1, got.ref_count_l1_minus1);
      check_one("init_qp_minus26", want.init_qp_minus26, got.init_qp_minus26);
      check_one("deblock_control_present", want.deblock_control_present,
                got.deblock_control_present);
      check_one("xform8_flag", want.xform8_flag, got.xform8_flag);
   endfunction
endclass

module h264_pps_header_parser_top_tb;
   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic [7:0] req_data_byte = 0;
   logic req_final_byte = 0;
   logic full, empty;
   wire hpps_pkg::rsp_type got;
   logic signed [31:0] qp_port;

   pps_scoreboard board;
   int requests_sent = 0;
   int hold_cycles = 0;
   bit bits_buf[$];

   always #1 clock = ~clock;

   h264_pps_header_parser_top dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_final_byte(req_final_byte),
      .empty(empty), .pop(pop), .rsp_status(got.status),
      .rsp_param_set_id(got.param_set_id), .rsp_seq_set_id(got.seq_set_id),
      .rsp_entropy_mode(got.entropy_mode),
      .rsp_ref_count_l0_minus1(got.ref_count_l0_minus1),
      .rsp_ref_count_l1_minus1(got.ref_count_l1_minus1),
      .rsp_init_qp_minus26(qp_port),
      .rsp_deblock_control_present(got.deblock_control_present),
      .rsp_xform8_flag(got.xform8_flag));
   assign got.init_qp_minus26 = qp_port;

   // Sends one request and waits for it to be accepted. The push line stays
   // high after acceptance so that requests can follow back to back; it drops
   // only while the sender idles.
   task automatic send_request(input bit [7:0] data, input bit last, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_data_byte <= data;
      req_final_byte <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_request(data, last);
      requests_sent++;
   endtask

   // Bit-string builders for well-formed parameter sets.
   function automatic void put_bits(bit [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) bits_buf.push_back(v[i]);
   endfunction

   function automatic void put_ue(bit [32:0] v);
      bit [32:0] x;
      int n;
      x = v + 1;
      n = 0;
      while ((x >> (n + 1)) != 0) n++;
      put_bits(0, n);
      put_bits(x, n + 1);
   endfunction

   function automatic void put_se(int v);
      if (v > 0) put_ue(2 * v - 1);
      else put_ue(-2 * v);
   endfunction

   function automatic bit [31:0] pick_ue();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(0, 3);
         2: return $urandom_range(0, 255);
         3: return $urandom;
         4: return 32'hffff_fffe;
         default: return $urandom_range(0, 31);
      endcase
   endfunction

   // Builds a random parameter set, mostly well formed, into bits_buf.
   function automatic void build_set(int shape);
      int g, mt, nlists;
      bit t8;
      bits_buf.delete();
      put_ue(pick_ue());
      put_ue(pick_ue());
      put_bits($urandom, 2);
      g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
      if (shape == 1) g = $urandom_range(8, 40);
      put_ue(g);
      if (g > 0) begin
         mt = $urandom_range(0, 6);
         if (shape == 2) mt = $urandom_range(7, 20);
         put_ue(mt);
         if (mt == 0) for (int i = 0; i <= g; i++) put_ue($urandom_range(0, 50));
         else if (mt == 2) for (int i = 0; i < 2 * g; i++) put_ue($urandom_range(0, 50));
         else if (mt >= 3 && mt <= 5) begin
            put_bits($urandom, 1);
            put_ue($urandom_range(0, 50));
         end else if (mt == 6) begin
            int sz;
            sz = $urandom_range(0, 12);
            if (shape == 3) sz = hpps_pkg::MaxMapUnits + $urandom_range(0, 9);
            put_ue(sz);
            if (shape != 3)
               for (int i = 0; i <= sz; i++)
                  put_bits($urandom, (g == 1) ? 1 : (g <= 3) ? 2 : 3);
         end
      end
      put_ue(pick_ue());
      put_ue(pick_ue());
      put_bits($urandom, 3);
      put_se($urandom_range(0, 1) ? -$urandom_range(0, 40) : $urandom_range(0, 40));
      put_se($urandom_range(0, 60) - 30);
      put_se($urandom_range(0, 24) - 12);
      put_bits($urandom, 3);
      if ($urandom_range(0, 1)) begin
         t8 = $urandom;
         put_bits(t8, 1);
         if ($urandom_range(0, 1)) begin
            put_bits(1, 1);
            nlists = t8 ? 8 : 6;
            for (int i = 0; i < nlists; i++) begin
               bit present;
               present = ($urandom_range(0, 3) == 0);
               put_bits(present, 1);
               if (present) begin
                  int cnt;
                  cnt = (i < 6) ? 16 : 64;
                  for (int j = 0; j < cnt; j++) put_se($urandom_range(0, 60) - 30);
               end
            end
         end else put_bits(0, 1);
         put_se($urandom_range(0, 24) - 12);
      end
      put_bits(1, 1);
      while (bits_buf.size() % 8 != 0) put_bits(0, 1);
      // Broken sets: cut short or with random trailing noise.
      if (shape == 4 && bits_buf.size() > 8)
         repeat ($urandom_range(1, bits_buf.size() / 8 - 1) * 8) void'(bits_buf.pop_back());
      if (shape == 5) put_bits($urandom, 8);
   endfunction

   task automatic send_set(input bit no_gap);
      int n;
      bit [7:0] b;
      n = bits_buf.size() / 8;
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < 8; k++) b[7 - k] = bits_buf[8 * i + k];
         send_request(b, i == n - 1, no_gap);
      end
   endtask

   task automatic wait_drained();
      push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Receiver: pops with random stalls, and one long hold-off.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         gap += hold_cycles;
         hold_cycles = 0;
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         @(posedge clock);
         while (empty) @(posedge clock);
         board.check_result(got);
      end
   end

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, long code, zero final byte and single stop byte.
      send_request(8'h00, 1, 0);
      send_request(8'h80, 1, 0);
      send_request(8'hff, 1, 0);
      repeat (4) send_request(8'h00, 0, 0);
      send_request(8'h01, 1, 0);
      bits_buf.delete();
      put_ue(32'hffff_fffe); put_ue(32'hffff_fffe); put_bits(3, 2); put_ue(0);
      put_ue(32'hffff_fffe); put_ue(32'hffff_fffe); put_bits(7, 3);
      put_se(32'sh7fff_ffff); put_se(0); put_se(0); put_bits(7, 3); put_bits(1, 1);
      while (bits_buf.size() % 8 != 0) put_bits(0, 1);
      send_set(0);
      for (int s = 0; s <= 5; s++) begin
         build_set(s);
         send_set(0);
      end

      // Pause: the sender waits for every result.
      wait_drained();

      // Long receiver hold-off while requests keep flowing.
      hold_cycles = 400;
      for (int i = 0; i < 4; i++) begin
         build_set(0);
         send_set(1);
      end
      wait_drained();

      // Random part: mostly well-formed sets, some broken or noisy.
      while (requests_sent < 1400) begin
         int r;
         r = $urandom_range(0, 19);
         if (r < 13) build_set(0);
         else build_set(r - 13 > 5 ? 4 : r - 13);
         if (r == 19) begin
            bits_buf.delete();
            repeat ($urandom_range(1, 6) * 8) put_bits($urandom, 1);
         end
         send_set(0);
      end

      wait_drained();
      $display("Sent %0d requests in parameter sets; checked %0d results.",
               requests_sent, board.results_seen);
      $display("Status counts ok/malformed/groups/map type/map size: %0d %0d %0d %0d %0d",
               board.status_hits[0], board.status_hits[1], board.status_hits[2],
               board.status_hits[3], board.status_hits[4]);
      if (board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Run limit well above the slowest correct run.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
